// File: hw/rtl/mhtu_pkg.sv
// Shared types and codes for the message hash table unit.
// No dependencies.

package mhtu_pkg;

    localparam int ID_W   = 64;
    localparam int DATA_W = 64;
    localparam int SIZE_W = 16;
    localparam int KIND_W = 8;
    localparam int STAT_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS     = 2'd3;

    // Bucket reduction step: bits of the id folded per cycle.
    localparam int MOD_STEP   = 8;
    localparam int MOD_CYCLES = ID_W / MOD_STEP;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    typedef struct packed {
        logic [ID_W-1:0]   key;
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic [KIND_W-1:0] kind;
    } t_entry;

endpackage

// File: hw/rtl/mhtu_mod.sv
// Bucket index: message id modulo BUCKETS.
// Power-of-two bucket counts reduce to a mask; others fold 8 bits a cycle.
// Depends on mhtu_pkg.

module mhtu_mod #(
    parameter int BUCKETS = 256,
    parameter int BW      = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mhtu_pkg::ID_W-1:0] i_id,
    output logic                      o_done,
    output logic [BW-1:0]             o_bucket
);

    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            assign o_done = i_start;
            if (BUCKETS > 1) begin : g_bits
                assign o_bucket = i_id[BW-1:0];
            end else begin : g_one
                assign o_bucket = '0;
            end
        end else begin : g_fold
            logic                             r_busy;
            logic                             r_done;
            logic [mhtu_pkg::MOD_CNT_W-1:0]   r_cnt;
            logic [mhtu_pkg::ID_W-1:0]        r_sh;
            logic [BW-1:0]                    r_rem;
            logic [BW-1:0]                    n_rem;

            always_comb begin
                logic [BW:0] t;
                t = {1'b0, r_rem};
                for (int k = 0; k < mhtu_pkg::MOD_STEP; k++) begin
                    t = {t[BW-1:0], r_sh[mhtu_pkg::ID_W-1-k]};
                    if (t >= (BW+1)'(BUCKETS)) begin
                        t = t - (BW+1)'(BUCKETS);
                    end
                end
                n_rem = t[BW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == mhtu_pkg::MOD_CNT_W'(mhtu_pkg::MOD_CYCLES - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_sh  <= i_id;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_sh  <= r_sh << mhtu_pkg::MOD_STEP;
                    r_rem <= n_rem;
                end
            end

            assign o_done   = r_done;
            assign o_bucket = r_rem;
        end
    endgenerate

endmodule

// File: hw/rtl/mhtu_store.sv
// Bucket storage: fill-count memory and a row memory of WAYS entries per bucket.
// Row writes merge one way into the row last read. Depends on mhtu_pkg.

module mhtu_store #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4,
    parameter int BW      = 8,
    parameter int FW      = 3,
    parameter int WW      = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [BW-1:0]                     i_rd_bucket,
    output logic [FW-1:0]                     o_rd_fill,
    output mhtu_pkg::t_entry [WAYS-1:0]       o_rd_row,
    input  logic                              i_fill_we,
    input  logic                              i_row_we,
    input  logic [BW-1:0]                     i_wr_bucket,
    input  logic [FW-1:0]                     i_wr_fill,
    input  logic [WW-1:0]                     i_wr_way,
    input  mhtu_pkg::t_entry                  i_wr_entry
);

    logic [FW-1:0]                 fill_mem [BUCKETS];
    mhtu_pkg::t_entry [WAYS-1:0]   row_mem  [BUCKETS];

    logic [FW-1:0]                 r_rd_fill;
    mhtu_pkg::t_entry [WAYS-1:0]   r_rd_row;
    mhtu_pkg::t_entry [WAYS-1:0]   row_wr;

    always_comb begin
        row_wr           = r_rd_row;
        row_wr[i_wr_way] = i_wr_entry;
    end

    always_ff @(posedge i_clk) begin
        if (i_fill_we) begin
            fill_mem[i_wr_bucket] <= i_wr_fill;
        end
        if (i_rd_en) begin
            r_rd_fill <= fill_mem[i_rd_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row_we) begin
            row_mem[i_wr_bucket] <= row_wr;
        end
        if (i_rd_en) begin
            r_rd_row <= row_mem[i_rd_bucket];
        end
    end

    assign o_rd_fill = r_rd_fill;
    assign o_rd_row  = r_rd_row;

endmodule

// File: hw/rtl/message_hash_table_unit.sv
// Message hash table unit: insert and find of records in a bucketed table.
// Result: registered after the row read and compare; the row read starts on
// accept (power-of-two BUCKETS) or after the id reduction and done pulse. One item
// in flight: the next is accepted once the result is registered, which waits
// while the output is stalled. Reset: a clearing pass writes every fill count to
// zero, with o_in_stall high. Depends on mhtu_pkg, mhtu_mod, mhtu_store.

module message_hash_table_unit #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [mhtu_pkg::ID_W-1:0]     i_msg_id,
    input  logic [mhtu_pkg::SIZE_W-1:0]   i_msg_size,
    input  logic [mhtu_pkg::KIND_W-1:0]   i_msg_kind,
    input  logic [mhtu_pkg::DATA_W-1:0]   i_msg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mhtu_pkg::STAT_W-1:0]   o_status,
    output logic [mhtu_pkg::SIZE_W-1:0]   o_found_size,
    output logic [mhtu_pkg::KIND_W-1:0]   o_found_kind,
    output logic [mhtu_pkg::DATA_W-1:0]   o_found_data
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FW = $clog2(WAYS + 1);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_MOD  = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [BW-1:0]                 r_clr;
    logic [BW-1:0]                 r_bucket;
    logic                          r_op;
    logic [mhtu_pkg::ID_W-1:0]     r_id;
    logic [mhtu_pkg::SIZE_W-1:0]   r_size;
    logic [mhtu_pkg::KIND_W-1:0]   r_kind;
    logic [mhtu_pkg::DATA_W-1:0]   r_data;

    logic                          r_out_valid;
    logic [mhtu_pkg::STAT_W-1:0]   r_status, n_status;
    logic [mhtu_pkg::SIZE_W-1:0]   r_fsize;
    logic [mhtu_pkg::KIND_W-1:0]   r_fkind;
    logic [mhtu_pkg::DATA_W-1:0]   r_fdata;
    mhtu_pkg::t_entry              n_found;

    logic                          accept;
    logic                          mod_done;
    logic [BW-1:0]                 mod_bucket;
    logic                          rd_en;
    logic                          out_free;
    logic                          finish;
    logic                          full;
    logic                          hit_any;
    logic [WW-1:0]                 hit_way;
    logic                          fill_we;
    logic                          row_we;
    logic [BW-1:0]                 wr_bucket;
    logic [FW-1:0]                 wr_fill;
    logic [FW-1:0]                 rd_fill;
    mhtu_pkg::t_entry [WAYS-1:0]   rd_row;
    mhtu_pkg::t_entry              wr_entry;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign rd_en      = mod_done && ((r_state == S_IDLE && accept) || r_state == S_MOD);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign finish     = (r_state == S_CMP) && out_free;

    mhtu_mod #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_id     ((r_state == S_IDLE) ? i_msg_id : r_id),
        .o_done   (mod_done),
        .o_bucket (mod_bucket)
    );

    mhtu_store #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .BW      (BW),
        .FW      (FW),
        .WW      (WW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_en     (rd_en),
        .i_rd_bucket (mod_bucket),
        .o_rd_fill   (rd_fill),
        .o_rd_row    (rd_row),
        .i_fill_we   (fill_we),
        .i_row_we    (row_we),
        .i_wr_bucket (wr_bucket),
        .i_wr_fill   (wr_fill),
        .i_wr_way    (rd_fill[WW-1:0]),
        .i_wr_entry  (wr_entry)
    );

    // Way compare over the filled ways; earliest way wins.
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((FW'(w) < rd_fill) && (rd_row[w].key == r_id)) begin
                hit_any = 1'b1;
                hit_way = WW'(w);
            end
        end
    end

    assign full           = (rd_fill >= FW'(WAYS));
    assign wr_entry.key   = r_id;
    assign wr_entry.data  = r_data;
    assign wr_entry.size  = r_size;
    assign wr_entry.kind  = r_kind;
    assign row_we         = finish && (r_op == mhtu_pkg::OP_INSERT) && !full;
    assign fill_we        = row_we || (r_state == S_CLR);
    assign wr_bucket      = (r_state == S_CLR) ? r_clr : r_bucket;
    assign wr_fill        = (r_state == S_CLR) ? '0 : rd_fill + 1'b1;

    always_comb begin
        n_found = '0;
        if (r_op == mhtu_pkg::OP_INSERT) begin
            n_status = full ? mhtu_pkg::ST_FULL : mhtu_pkg::ST_INSERTED;
        end else if (hit_any) begin
            n_status = mhtu_pkg::ST_FOUND;
            n_found  = rd_row[hit_way];
        end else begin
            n_status = mhtu_pkg::ST_MISS;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = mod_done ? S_CMP : S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_id   <= i_msg_id;
            r_size <= i_msg_size;
            r_kind <= i_msg_kind;
            r_data <= i_msg_data;
        end
        if (rd_en) begin
            r_bucket <= mod_bucket;
        end
        if (finish) begin
            r_status <= n_status;
            r_fsize  <= n_found.size;
            r_fkind  <= n_found.kind;
            r_fdata  <= n_found.data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_found_size = r_fsize;
    assign o_found_kind = r_fkind;
    assign o_found_data = r_fdata;

endmodule
